@@ hw/rtl/brb_pkg.sv @@
// ----------------------------------------------------------------------------
// brb_pkg : shared types and constants of the byte ring buffer
// Field widths, command codes, controller/datapath handshake structs and the
// ring index advance helper.
// ----------------------------------------------------------------------------
package brb_pkg;

  // Fixed field widths
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned START_W = 10;

  // Parameter defaults
  localparam int unsigned DEPTH_DEF          = 1024;
  localparam int unsigned MAX_READ_BURST_DEF = 64;

  // Capacity after reset
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SKIP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic latch;  // capture the input item
    logic exec;   // run the captured command
    logic fetch;  // pop one byte into the output register
  } brb_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic read_go;  // read command with at least one byte to return
    logic last;     // result register holds the final result of the command
  } brb_sts_t;

  // Ring advance: idx < cap and n <= cap, so one compare and subtract wraps it
  function automatic logic [CNT_W-1:0] brb_adv(input logic [CNT_W-1:0] idx,
                                               input logic [CNT_W-1:0] n,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] s;
    s = {1'b0, idx} + {1'b0, n};
    if (s >= {1'b0, cap}) begin
      s = s - {1'b0, cap};
    end
    return s[CNT_W-1:0];
  endfunction

endpackage

@@ hw/rtl/brb_ctrl.sv @@
// ----------------------------------------------------------------------------
// brb_ctrl : command sequencer of the byte ring buffer
// Takes one item at a time, runs it, then holds the result until taken. A
// read loops fetch/show once per byte.
// ----------------------------------------------------------------------------
module brb_ctrl
  import brb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  output brb_ctl_t ctl_o,
  input  brb_sts_t sts_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_RESP  = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_SHOW  = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    ctl_o     = '0;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = sts_i.read_go ? ST_FETCH : ST_RESP;
      end
      ST_FETCH: begin
        ctl_o.fetch = 1'b1;
        state_d     = ST_SHOW;
      end
      ST_SHOW: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          state_d = sts_i.last ? ST_IDLE : ST_FETCH;
        end
      end
      ST_RESP: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/brb_datapath.sv @@
// ----------------------------------------------------------------------------
// brb_datapath : storage, indices and result registers of the byte ring buffer
// Holds the byte memory, read/write indices, fill level, capacity register and
// the registered result fields.
// ----------------------------------------------------------------------------
module brb_datapath
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH          = DEPTH_DEF,
  parameter int unsigned MAX_READ_BURST = MAX_READ_BURST_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CNT_W-1:0]   cfg_wdata_i,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic [DATA_W-1:0]  data_in_i,
  input  brb_ctl_t           ctl_i,
  output brb_sts_t           sts_o,
  output logic [DATA_W-1:0]  data_out_o,
  output logic               data_valid_o,
  output logic [CNT_W-1:0]   done_count_o,
  output logic [START_W-1:0] first_start_o,
  output logic [CNT_W-1:0]   first_length_o,
  output logic [CNT_W-1:0]   second_length_o,
  output logic [CNT_W-1:0]   fill_level_o,
  output logic               last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned RW = $clog2(MAX_READ_BURST + 1);
  // Largest capacity the register can express in this depth
  localparam logic [CNT_W-1:0] CAP_MAX =
    (DEPTH > 2047) ? 11'd2047 : CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] BURST_MAX = CNT_W'(MAX_READ_BURST);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]   cap_q;
  logic [CNT_W-1:0]   level_q, rd_idx_q, wr_idx_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [CNT_W-1:0]   count_q;
  logic [DATA_W-1:0]  din_q;
  logic [RW-1:0]      rem_q;
  logic [DATA_W-1:0]  rdata_q;
  logic               dv_q, last_q;
  logic [CNT_W-1:0]   done_q, flen_q, slen_q;
  logic [START_W-1:0] fstart_q;

  logic [CNT_W-1:0] eff_cap, avail, free_sp, rsv_n, room, first_n, burst;
  logic             wr_ok;
  logic [AW-1:0]    wr_addr, rd_addr;

  // Effective capacity: zero acts as one, clamp to the depth
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_q > CAP_MAX) begin
      eff_cap = CAP_MAX;
    end else begin
      eff_cap = cap_q;
    end
  end

  // Clamped counts for the captured command
  always_comb begin
    avail   = (count_q < level_q) ? count_q : level_q;
    free_sp = eff_cap - level_q;
    rsv_n   = (count_q < free_sp) ? count_q : free_sp;
    room    = eff_cap - rd_idx_q;
    first_n = (avail <= room) ? avail : room;
    burst   = (avail > BURST_MAX) ? BURST_MAX : avail;
    wr_ok   = level_q < eff_cap;
  end

  // Memory addresses (indices always stay below the depth)
  if (AW > CNT_W) begin : g_addr_ext
    assign wr_addr = {{(AW-CNT_W){1'b0}}, wr_idx_q};
    assign rd_addr = {{(AW-CNT_W){1'b0}}, rd_idx_q};
  end else begin : g_addr_cut
    assign wr_addr = wr_idx_q[AW-1:0];
    assign rd_addr = rd_idx_q[AW-1:0];
  end

  assign sts_o.read_go = (cmd_q == CMD_READ) && (burst != '0);
  assign sts_o.last    = last_q;

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec && (cmd_q == CMD_WRITE) && wr_ok) begin
      mem[wr_addr] <= din_q;
    end
    if (ctl_i.fetch) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Captured input item
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q   <= command_i;
      count_q <= count_i;
      din_q   <= data_in_i;
    end
  end

  // Ring state and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAP_RESET;
      level_q  <= '0;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      rem_q    <= '0;
    end else if (cfg_we_i) begin
      cap_q    <= cfg_wdata_i;
      level_q  <= '0;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
    end else if (ctl_i.exec) begin
      case (cmd_q)
        CMD_WRITE: begin
          if (wr_ok) begin
            wr_idx_q <= brb_adv(wr_idx_q, CNT_W'(1), eff_cap);
            level_q  <= level_q + CNT_W'(1);
          end
        end
        CMD_READ: begin
          rem_q <= RW'(burst);
        end
        CMD_SKIP: begin
          rd_idx_q <= brb_adv(rd_idx_q, avail, eff_cap);
          level_q  <= level_q - avail;
        end
        CMD_RESERVE: begin
          wr_idx_q <= brb_adv(wr_idx_q, rsv_n, eff_cap);
          level_q  <= level_q + rsv_n;
        end
        default: begin
        end
      endcase
    end else if (ctl_i.fetch) begin
      rd_idx_q <= brb_adv(rd_idx_q, CNT_W'(1), eff_cap);
      level_q  <= level_q - CNT_W'(1);
      rem_q    <= rem_q - RW'(1);
    end
  end

  // Result fields
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      dv_q     <= 1'b0;
      last_q   <= 1'b1;
      done_q   <= '0;
      fstart_q <= '0;
      flen_q   <= '0;
      slen_q   <= '0;
      case (cmd_q)
        CMD_WRITE:   done_q <= wr_ok ? CNT_W'(1) : '0;
        CMD_READ:    done_q <= burst;
        CMD_SKIP:    done_q <= avail;
        CMD_RESERVE: done_q <= rsv_n;
        CMD_PEEK: begin
          done_q   <= avail;
          fstart_q <= rd_idx_q[START_W-1:0];
          flen_q   <= first_n;
          slen_q   <= avail - first_n;
        end
        default: begin
        end
      endcase
    end else if (ctl_i.fetch) begin
      dv_q   <= 1'b1;
      last_q <= (rem_q == RW'(1));
    end
  end

  assign data_out_o      = dv_q ? rdata_q : '0;
  assign data_valid_o    = dv_q;
  assign done_count_o    = done_q;
  assign first_start_o   = fstart_q;
  assign first_length_o  = flen_q;
  assign second_length_o = slen_q;
  assign fill_level_o    = level_q;
  assign last_o          = last_q;

endmodule

@@ hw/rtl/byte_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer : circular byte FIFO with read, skip, reserve and peek
//
//   channel  dir  handshake                    payload
//   s_axis   in   s_axis_tvalid/s_axis_tready  tuser command, tdata count+byte
//   m_axis   out  m_axis_tvalid/m_axis_tready  tdata result, tuser data_valid,
//                                              tlast last result of a command
//   cfg      in   cfg_we_i                     capacity, clears the ring
//
// One item is handled at a time. A non-read command steps through accept,
// execute and result. A read that returns n bytes steps through accept and
// execute, then gives n results, each a fetch then a show, set by the
// registered read port of the byte memory. Output stalls hold the result
// register and the sequencer. Reset clears indices and level and sets the
// capacity to 1024; it does not clear the byte memory.
// ----------------------------------------------------------------------------
module byte_ring_buffer
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH          = DEPTH_DEF,
  parameter int unsigned MAX_READ_BURST = MAX_READ_BURST_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // capacity register
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  // input items
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,   // count[10:0], data_in[18:11], zeros
  input  logic [2:0]       s_axis_tuser,   // command[2:0]
  // result items
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // data_out[7:0], done_count[18:8], first_start[28:19], first_length[39:29],
  // second_length[50:40], fill_level[61:51], zeros[63:62]
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tuser,   // data_valid
  output logic             m_axis_tlast
);

  brb_ctl_t ctl;
  brb_sts_t sts;

  logic [DATA_W-1:0]  data_out;
  logic [CNT_W-1:0]   done_count, first_length, second_length, fill_level;
  logic [START_W-1:0] first_start;

  brb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .ctl_o     (ctl),
    .sts_i     (sts)
  );

  brb_datapath #(
    .DEPTH          (DEPTH),
    .MAX_READ_BURST (MAX_READ_BURST)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (s_axis_tuser),
    .count_i         (s_axis_tdata[10:0]),
    .data_in_i       (s_axis_tdata[18:11]),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .data_out_o      (data_out),
    .data_valid_o    (m_axis_tuser),
    .done_count_o    (done_count),
    .first_start_o   (first_start),
    .first_length_o  (first_length),
    .second_length_o (second_length),
    .fill_level_o    (fill_level),
    .last_o          (m_axis_tlast)
  );

  // Result packing, lowest field first
  assign m_axis_tdata = {2'b00, fill_level, second_length, first_length,
                         first_start, done_count, data_out};

  // One item in flight: no accept while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while a result is pending");

  // Only read bytes can be followed by more results of the same command
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("non-data result without last mark");

  // Final result taken returns the block to accepting items
  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("not ready after final result");

endmodule

@@ dv/brb_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brb_checker : result predictor and scoreboard for the byte ring buffer
// Watches the config port and both streams, predicts the results of every
// accepted item from its own copy of the ring, and compares each accepted
// result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module brb_checker
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned MAX_BURST = MAX_READ_BURST_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CNT_W-1:0]   cfg_wdata_i,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // count[10:0], data_in[18:11], zeros
  input  logic [2:0]         s_axis_tuser,   // command[2:0]
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [63:0]        m_axis_tdata,   // data_out .. fill_level, zeros
  input  logic               m_axis_tuser,   // data_valid
  input  logic               m_axis_tlast,
  output logic [31:0]        mismatch_count_o,
  output logic [31:0]        pending_o,
  output logic [31:0]        checked_o,
  output logic [CNT_W-1:0]   level_o,
  output logic [CNT_W-1:0]   rd_index_o,
  output logic [CNT_W-1:0]   cap_o,
  output logic [DEPTH-1:0]   written_o
);

  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic               data_valid;
    logic [CNT_W-1:0]   done_count;
    logic [START_W-1:0] first_start;
    logic [CNT_W-1:0]   first_length;
    logic [CNT_W-1:0]   second_length;
    logic [CNT_W-1:0]   fill_level;
    logic               last;
  } brb_result_t;

  brb_result_t       expected_results[$];
  logic [DATA_W-1:0] ring_bytes[DEPTH];
  logic [DEPTH-1:0]  written;
  logic [CNT_W-1:0]  cap_raw;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  wr_idx;
  logic [CNT_W-1:0]  fill;
  int unsigned       mismatches;
  int unsigned       checked;

  assign written_o = written;

  // 0 behaves as 1, anything above the memory size as the memory size
  function automatic logic [CNT_W-1:0] eff_capacity(input logic [CNT_W-1:0] raw);
    if (raw == '0) return CNT_W'(1);
    if (raw > DEPTH) return CNT_W'(DEPTH);
    return raw;
  endfunction

  function automatic logic [CNT_W-1:0] wrap_add(input logic [CNT_W-1:0] idx,
                                                input logic [CNT_W-1:0] n,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] sum;
    sum = idx + n;
    if (sum >= cap) sum = sum - cap;
    return sum[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] min_cnt(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  task automatic push_result(input logic [DATA_W-1:0]  dout,
                             input logic               dvalid,
                             input logic [CNT_W-1:0]   done,
                             input logic [START_W-1:0] fstart,
                             input logic [CNT_W-1:0]   flen,
                             input logic [CNT_W-1:0]   slen,
                             input logic               lst);
    brb_result_t r;
    r = {dout, dvalid, done, fstart, flen, slen, fill, lst};
    expected_results.push_back(r);
  endtask

  // Expected results of one accepted command; updates the ring copy
  task automatic predict_command(input logic [CMD_W-1:0]  cmd,
                                 input logic [CNT_W-1:0]  cnt,
                                 input logic [DATA_W-1:0] din);
    logic [CNT_W-1:0]  cap;
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  seg;
    logic [DATA_W-1:0] byte_out;
    int unsigned       k;
    cap = eff_capacity(cap_raw);
    case (cmd)
      CMD_WRITE: begin
        n = '0;
        if (fill < cap) begin
          ring_bytes[wr_idx] = din;
          written[wr_idx] = 1'b1;
          wr_idx = wrap_add(wr_idx, CNT_W'(1), cap);
          fill = fill + 1'b1;
          n = CNT_W'(1);
        end
        push_result('0, 1'b0, n, '0, '0, '0, 1'b1);
      end
      CMD_READ: begin
        n = min_cnt(cnt, fill);
        if (n > MAX_BURST) n = CNT_W'(MAX_BURST);
        if (n == '0) push_result('0, 1'b0, '0, '0, '0, '0, 1'b1);
        for (k = 0; k < n; k++) begin
          byte_out = ring_bytes[rd_idx];
          rd_idx = wrap_add(rd_idx, CNT_W'(1), cap);
          fill = fill - 1'b1;
          push_result(byte_out, 1'b1, n, '0, '0, '0, (k + 1 == n));
        end
      end
      CMD_SKIP: begin
        n = min_cnt(cnt, fill);
        rd_idx = wrap_add(rd_idx, n, cap);
        fill = fill - n;
        push_result('0, 1'b0, n, '0, '0, '0, 1'b1);
      end
      CMD_RESERVE: begin
        n = min_cnt(cnt, cap - fill);
        wr_idx = wrap_add(wr_idx, n, cap);
        fill = fill + n;
        push_result('0, 1'b0, n, '0, '0, '0, 1'b1);
      end
      CMD_PEEK: begin
        n = min_cnt(cnt, fill);
        seg = min_cnt(n, cap - rd_idx);
        push_result('0, 1'b0, n, rd_idx[START_W-1:0], seg, n - seg, 1'b1);
      end
      // unused codes: no operation, only the level and the last mark
      default: push_result('0, 1'b0, '0, '0, '0, '0, 1'b1);
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: result %0d field %s expected %0h got %0h",
                 checked, name, want, got);
    end
  endtask

  // Scoreboard: results of earlier items first, then config, then the new item
  always @(posedge clk_i) begin : scoreboard
    brb_result_t got;
    brb_result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      written = '0;
      cap_raw = CAP_RESET;
      rd_idx = '0;
      wr_idx = '0;
      fill = '0;
      mismatches = 0;
      checked = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[18:8], m_axis_tdata[28:19],
               m_axis_tdata[39:29], m_axis_tdata[50:40], m_axis_tdata[61:51], m_axis_tlast};
        checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: result %0d arrived with nothing expected (tdata %0h)",
                     checked, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("data_out", got.data_out, want.data_out);
          check_field("data_valid", got.data_valid, want.data_valid);
          check_field("done_count", got.done_count, want.done_count);
          check_field("first_start", got.first_start, want.first_start);
          check_field("first_length", got.first_length, want.first_length);
          check_field("second_length", got.second_length, want.second_length);
          check_field("fill_level", got.fill_level, want.fill_level);
          check_field("last", got.last, want.last);
        end
      end
      // capacity write empties the ring
      if (cfg_we_i) begin
        cap_raw = cfg_wdata_i;
        rd_idx = '0;
        wr_idx = '0;
        fill = '0;
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_command(s_axis_tuser, s_axis_tdata[10:0], s_axis_tdata[18:11]);
    end
    mismatch_count_o = mismatches;
    pending_o = expected_results.size();
    checked_o = checked;
    level_o = fill;
    rd_index_o = rd_idx;
    cap_o = eff_capacity(cap_raw);
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb : stimulus and verdict for the byte ring buffer
// Drives directed corner items, then phases at several capacities mixing
// wrap-around sequences, read bursts and random commands, with random idle
// gaps on both streams and one long output stall. Checking is done by
// brb_checker.
// ----------------------------------------------------------------------------
module tb;
  import brb_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_500_000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 20;

  localparam logic [CNT_W-1:0] CNT_ALL    = '1;
  localparam logic [CMD_W-1:0] CMD_NOP_LO = CMD_PEEK + 1'b1;
  localparam logic [CMD_W-1:0] CMD_NOP_HI = '1;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CNT_W-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata;   // count[10:0], data_in[18:11], zeros
  logic [2:0]         s_axis_tuser;   // command[2:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [63:0]        m_axis_tdata;   // data_out .. fill_level, zeros
  logic               m_axis_tuser;   // data_valid
  logic               m_axis_tlast;

  logic [31:0]          mismatch_count;
  logic [31:0]          pending;
  logic [31:0]          checked;
  logic [CNT_W-1:0]     ring_level;
  logic [CNT_W-1:0]     ring_rd;
  logic [CNT_W-1:0]     ring_cap;
  logic [DEPTH_DEF-1:0] ring_written;

  logic        idle_on;
  logic        long_hold;
  logic        hold_done;
  int unsigned items_sent;
  int unsigned cap_settings;

  byte_ring_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  brb_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .level_o          (ring_level),
    .rd_index_o       (ring_rd),
    .cap_o            (ring_cap),
    .written_o        (ring_written)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  // Result side: random ready gaps per item, plus one long hold-off
  initial begin : result_sink
    int unsigned gap;
    m_axis_tready = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold && !hold_done) begin
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_done = 1'b1;
      end
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Idle gap before the next item; leaves us at a falling edge
  task automatic next_slot();
    int unsigned gap;
    @(negedge clk_i);
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] cnt,
                       input logic [DATA_W-1:0] din);
    s_axis_tuser = cmd;
    s_axis_tdata = {5'b0, din, cnt};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] cnt,
                      input logic [DATA_W-1:0] din);
    next_slot();
    offer(cmd, cnt, din);
  endtask

  // Capacity write once the ring has delivered every result
  task automatic set_capacity(input logic [CNT_W-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_wdata_i = value;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cap_settings++;
  endtask

  // Bytes readable from the read index before hitting a never-written entry
  function automatic int unsigned safe_read_span();
    int unsigned k;
    int unsigned idx;
    k = 0;
    idx = ring_rd;
    while (k < ring_level && k < MAX_READ_BURST_DEF && ring_written[idx]) begin
      k++;
      idx = (idx + 1 == ring_cap) ? 0 : idx + 1;
    end
    return k;
  endfunction

  task automatic random_item();
    int unsigned pick;
    int unsigned span;
    int unsigned burst;
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] cnt;
    next_slot();
    pick = $urandom_range(0, 99);
    if (pick < 40)      cmd = CMD_WRITE;
    else if (pick < 60) cmd = CMD_READ;
    else if (pick < 68) cmd = CMD_SKIP;
    else if (pick < 76) cmd = CMD_RESERVE;
    else if (pick < 94) cmd = CMD_PEEK;
    else                cmd = CMD_W'($urandom_range(CMD_NOP_LO, CMD_NOP_HI));
    pick = $urandom_range(0, 99);
    if (pick < 55)      cnt = CNT_W'($urandom_range(0, ring_cap + 2));
    else if (pick < 85) cnt = CNT_W'($urandom_range(0, 8));
    else                cnt = CNT_W'($urandom);
    // keep reads off entries that a reserve passed over unwritten
    if (cmd == CMD_READ) begin
      span = safe_read_span();
      burst = (ring_level < MAX_READ_BURST_DEF) ? ring_level : MAX_READ_BURST_DEF;
      if (span < burst) cnt = CNT_W'($urandom_range(0, span));
    end
    offer(cmd, cnt, DATA_W'($urandom));
  endtask

  // Move both indices by rsv, then write and read back across the wrap point
  task automatic wrap_run(input int unsigned rsv, input int unsigned nbytes);
    send(CMD_SKIP, CNT_ALL, '0);
    send(CMD_RESERVE, CNT_W'(rsv), DATA_W'($urandom));
    send(CMD_SKIP, CNT_ALL, '0);
    repeat (nbytes) send(CMD_WRITE, CNT_W'($urandom), DATA_W'($urandom));
    send(CMD_PEEK, CNT_ALL, '0);
    send(CMD_PEEK, CNT_W'($urandom_range(0, nbytes)), '0);
    send(CMD_READ, CNT_ALL, '0);
    send(CMD_READ, CNT_ALL, '0);
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] cap_val, input logic idle,
                           input int unsigned rsv, input int unsigned nbytes,
                           input int unsigned n_random);
    set_capacity(cap_val);
    idle_on = idle;
    if (nbytes > 0) wrap_run(rsv, nbytes);
    repeat (n_random) random_item();
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int unsigned c;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    idle_on = 1'b1;
    long_hold = 1'b0;
    items_sent = 0;
    cap_settings = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners at the reset capacity
    send(CMD_READ, CNT_W'(5), '0);          // nothing to read
    send(CMD_PEEK, CNT_W'(3), '0);
    send(CMD_SKIP, CNT_W'(3), '0);
    send(CMD_WRITE, '0, 8'h00);
    send(CMD_WRITE, CNT_ALL, 8'hFF);
    send(CMD_WRITE, '0, 8'hA5);
    send(CMD_WRITE, '0, 8'h5A);
    send(CMD_PEEK, CNT_ALL, '0);            // clamped to the level
    send(CMD_READ, CNT_W'(2), '0);
    send(CMD_READ, '0, '0);                 // zero-length read with data held
    send(CMD_SKIP, CNT_W'(1), '0);
    send(CMD_RESERVE, '0, '0);
    send(CMD_RESERVE, CNT_ALL, '0);         // clamped to free space, ring full
    send(CMD_WRITE, '0, 8'h33);             // write when full
    send(CMD_PEEK, CNT_ALL, '0);            // full ring, split segments
    send(CMD_SKIP, CNT_ALL, '0);
    send(CMD_READ, CNT_W'(1), '0);
    send(CMD_NOP_LO, CNT_ALL, 8'hFF);
    send(CMD_NOP_HI, '0, '0);

    // Capacity above the memory size, wrap at the top of the memory
    run_phase(CNT_ALL, 1'b1, 1000, 40, 15);
    // Capacity zero and one: single-entry ring
    run_phase('0, 1'b1, 0, 1, 20);
    run_phase(CNT_W'(1), 1'b0, 0, 1, 15);

    // Read bursts; the output side stalls long while items are offered
    set_capacity(CNT_W'(90));
    idle_on = 1'b0;
    long_hold = 1'b1;
    repeat (80) send(CMD_WRITE, CNT_W'($urandom), DATA_W'($urandom));
    send(CMD_READ, CNT_ALL, '0);
    send(CMD_READ, CNT_ALL, '0);
    idle_on = 1'b1;
    repeat (20) random_item();

    run_phase(CNT_W'(3), 1'b1, 2, 3, 30);
    run_phase(CNT_W'(DEPTH_DEF), 1'b1, $urandom_range(900, DEPTH_DEF - 1), 30, 25);
    run_phase(CNT_W'(DEPTH_DEF + 1), 1'b0, $urandom_range(1000, DEPTH_DEF - 1), 10, 15);
    for (int i = 0; i < 3; i++) begin
      c = $urandom_range(2, 64);
      run_phase(CNT_W'(c), i[0], $urandom_range(0, c - 1),
                $urandom_range(1, (c < 32) ? c : 32), 10);
    end

    // Drain
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("summary: %0d items over %0d capacity settings, %0d results compared",
             items_sent, cap_settings, checked);
    $display("summary: empty and full clamps, read bursts, wrapped peeks, unused codes, "
             , "long output stall");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ byte_ring_buffer.f @@
hw/rtl/brb_pkg.sv
hw/rtl/brb_ctrl.sv
hw/rtl/brb_datapath.sv
hw/rtl/byte_ring_buffer.sv
dv/brb_checker.sv
dv/tb.sv
